[hw/rtl/stbs_pkg.sv]
// Shared types and constants for the sorted-table binary search block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package stbs_pkg;

   localparam int INDEX_WIDTH     = 8;
   localparam int INDEX_RANGE     = 2 ** INDEX_WIDTH;
   localparam int KEY_WIDTH       = 32;
   localparam int BOUND_WIDTH     = 9;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = BOUND_WIDTH;

   typedef logic        [INDEX_WIDTH-1:0]     index_type;
   typedef logic signed [KEY_WIDTH-1:0]       key_type;
   typedef logic signed [BOUND_WIDTH-1:0]     bound_type;
   typedef logic        [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic        [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam csr_index_type CSR_LOW_BOUND  = 1'b0;
   localparam csr_index_type CSR_HIGH_BOUND = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/stbs_if.sv]
// Request and response channel interfaces (valid/ready beats).
// Depends on stbs_pkg for payload types.
`default_nettype none

interface stbs_req_if;
   import stbs_pkg::*;

   logic      valid;
   logic      ready;
   logic      operation;
   index_type entry_index;
   key_type   entry_value;
   key_type   search_key;

   modport source (output valid, operation, entry_index, entry_value, search_key,
                   input ready);
   modport sink   (input valid, operation, entry_index, entry_value, search_key,
                   output ready);
endinterface

interface stbs_rsp_if;
   import stbs_pkg::*;

   logic      valid;
   logic      ready;
   logic      found;
   index_type position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

[hw/rtl/stbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hw/rtl/sorted_table_binary_search_top.sv]
// Load beats write the table at the accept edge with no response, one per cycle
// while no search is in progress. Search: each probe reads the RAM (PROBE), then
// compares (COMPARE); a hit responds from COMPARE, a miss from PROBE on an empty range;
// at most 9 probes. Req ready stays low until the response registers, which waits
// while rsp ready holds the last response. Depends on stbs_pkg, stbs_if, stbs_ram.
// Reset (sync, active high) clears sequencer, rsp valid, bounds (low 0, high -1).
`default_nettype none

module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   stbs_req_if.sink                    req_bus,
   stbs_rsp_if.source                  rsp_bus,
   input  wire logic                   csr_wr_en,
   input  wire stbs_pkg::csr_index_type csr_index,
   input  wire stbs_pkg::csr_data_type  csr_wr_data
);
   import stbs_pkg::*;

   localparam int ADDR_WIDTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_PROBE   = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;

   typedef logic [ADDR_WIDTH-1:0] addr_map_type [INDEX_RANGE];
   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   function automatic addr_map_type build_addr_map();
      addr_map_type m;
      for (int i = 0; i < INDEX_RANGE; i++) begin
         m[i] = ADDR_WIDTH'(i % TABLE_DEPTH);
      end
      return m;
   endfunction

   localparam addr_map_type ADDR_MAP = build_addr_map();

   logic [1:0]             state_ff, state_in;
   logic [INDEX_WIDTH-1:0] low_bound_ff, low_bound_in;
   bound_type              high_bound_ff, high_bound_in;
   logic [BOUND_WIDTH-1:0] lo_ff, lo_in;
   bound_type              hi_ff, hi_in;
   index_type              mid_ff, mid_in;
   value_type              key_ff, key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   index_type              rsp_position_ff, rsp_position_in;

   logic                   req_accept;
   logic                   out_free;
   logic                   finish;
   logic                   range_empty;
   logic [INDEX_WIDTH:0]   mid_sum;
   index_type              mid_comb;
   logic [ADDR_WIDTH-1:0]  rd_addr;
   value_type              rd_value;
   value_type              wr_value;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign wr_value      = VALUE_WIDTH'(req_bus.entry_value);

   assign range_empty = $signed({1'b0, lo_ff}) > $signed({hi_ff[BOUND_WIDTH-1], hi_ff});
   assign mid_sum     = {1'b0, lo_ff[INDEX_WIDTH-1:0]} + {1'b0, hi_ff[INDEX_WIDTH-1:0]};
   assign mid_comb    = mid_sum[INDEX_WIDTH:1];
   assign rd_addr     = (state_ff == ST_PROBE) ? ADDR_MAP[mid_comb] : ADDR_MAP[mid_ff];

   stbs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_accept && (req_bus.operation == OP_LOAD)),
      .wr_addr (ADDR_MAP[req_bus.entry_index]),
      .wr_data (wr_value),
      .rd_addr (rd_addr),
      .rd_data (rd_value)
   );

   always_comb begin
      state_in        = state_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      key_in          = key_ff;
      finish          = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      low_bound_in    = low_bound_ff;
      high_bound_in   = high_bound_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_BOUND:  low_bound_in  = csr_wr_data[INDEX_WIDTH-1:0];
            CSR_HIGH_BOUND: high_bound_in = $signed(csr_wr_data);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_bus.operation == OP_SEARCH)) begin
               lo_in    = {1'b0, low_bound_ff};
               hi_in    = high_bound_ff;
               key_in   = VALUE_WIDTH'(req_bus.search_key);
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (range_empty) begin
               if (out_free) begin
                  finish          = 1'b1;
                  rsp_found_in    = 1'b0;
                  rsp_position_in = '0;
                  state_in        = ST_IDLE;
               end
            end else begin
               mid_in   = mid_comb;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (rd_value == key_ff) begin
               if (out_free) begin
                  finish          = 1'b1;
                  rsp_found_in    = 1'b1;
                  rsp_position_in = mid_ff;
                  state_in        = ST_IDLE;
               end
            end else if (rd_value < key_ff) begin
               lo_in    = {1'b0, mid_ff} + BOUND_WIDTH'(1);
               state_in = ST_PROBE;
            end else begin
               hi_in    = $signed({1'b0, mid_ff}) - BOUND_WIDTH'(1);
               state_in = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         low_bound_ff  <= '0;
         high_bound_ff <= '1;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         low_bound_ff  <= low_bound_in;
         high_bound_ff <= high_bound_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      key_ff          <= key_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.found    = rsp_found_ff;
   assign rsp_bus.position = rsp_position_ff;

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for sorted_table_binary_search_top: queued load/search beats,
// bursty sender, stalling receiver, in-bench lookup predictor with ordered compare.
// Depends on stbs_pkg, stbs_if and the RTL of the top level.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import stbs_pkg::*;

   localparam int     RANDOM_ITEMS  = 1600;
   localparam int     SETTLE_CYCLES = 24;
   localparam int     HOLD_CYCLES   = 400;
   localparam key_type KEY_MIN      = {1'b1, {(KEY_WIDTH-1){1'b0}}};
   localparam key_type KEY_MAX      = {1'b0, {(KEY_WIDTH-1){1'b1}}};

   typedef struct {
      logic      operation;
      index_type entry_index;
      key_type   entry_value;
      key_type   search_key;
   } table_op_type;

   typedef struct {
      logic      found;
      index_type position;
   } search_answer_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   csr_data_type  csr_wr_data;

   stbs_req_if req_bus ();
   stbs_rsp_if rsp_bus ();

   sorted_table_binary_search_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   table_op_type      op_queue[$];
   search_answer_type answer_queue[$];

   key_type   stim_table  [INDEX_RANGE];
   key_type   model_table [INDEX_RANGE];
   index_type model_low;
   bound_type model_high;

   bit             req_beat;
   bit             hold_off;
   bit             pressure_go;
   int             burst_left;
   int             gap_left;
   int             stall_left;
   ready_mode_type stall_mode;

   int queued_items;
   int load_count;
   int search_count;
   int hit_count;
   int setting_count;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("sorted_table_binary_search_top regression: fail");
      $finish;
   end

   function automatic search_answer_type predict_lookup(key_type key);
      int lo;
      int hi;
      int mid;
      search_answer_type ans;
      lo = int'(model_low);
      hi = int'(model_high);
      ans.found = 1'b0;
      ans.position = '0;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (model_table[mid % INDEX_RANGE] == key) begin
            ans.found = 1'b1;
            ans.position = index_type'(mid);
            return ans;
         end
         if (model_table[mid % INDEX_RANGE] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      return ans;
   endfunction

   function automatic void push_load(int idx, key_type value);
      table_op_type it;
      it.operation = OP_LOAD;
      it.entry_index = index_type'(idx);
      it.entry_value = value;
      it.search_key = key_type'($urandom);
      op_queue.push_back(it);
      stim_table[idx % INDEX_RANGE] = value;
      queued_items++;
   endfunction

   function automatic void push_search(key_type key);
      table_op_type it;
      it.operation = OP_SEARCH;
      it.entry_index = index_type'($urandom);
      it.entry_value = key_type'($urandom);
      it.search_key = key;
      op_queue.push_back(it);
      queued_items++;
   endfunction

   // Load the whole range, non-decreasing, in shuffled order, then mix searches.
   function automatic void plan_phase(int lo, int hi, int searches);
      int      n;
      int      i;
      int      j;
      int      tmp;
      int      pick;
      int      step;
      longint  v;
      int      order[$];
      key_type vals[$];
      key_type key;
      n = hi - lo + 1;
      if (n > 0) begin
         case ($urandom_range(0, 3))
            0: step = 1;
            1: step = 16;
            2: step = 1 << 20;
            default: step = 1 << 26;
         endcase
         v = ($urandom_range(0, 7) == 0) ? longint'(KEY_MIN) : longint'(key_type'($urandom));
         for (i = 0; i < n; i++) begin
            if (v > longint'(KEY_MAX)) v = longint'(KEY_MAX);
            vals.push_back(key_type'(v));
            order.push_back(lo + i);
            v = v + $urandom_range(0, step);
         end
         for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         for (i = 0; i < n; i++) push_load(order[i], vals[order[i] - lo]);
      end
      repeat (searches) begin
         if ($urandom_range(0, 11) == 0) push_load($urandom_range(0, 255), key_type'($urandom));
         pick = $urandom_range(0, 9);
         if (n > 0 && pick < 5) begin
            key = stim_table[lo + $urandom_range(0, n - 1)];
         end else if (n > 0 && pick < 7) begin
            key = stim_table[lo + $urandom_range(0, n - 1)] + ((pick == 5) ? 1 : -1);
         end else if (pick == 7) begin
            key = KEY_MIN;
         end else if (pick == 8) begin
            key = KEY_MAX;
         end else begin
            key = key_type'($urandom);
         end
         push_search(key);
      end
   endfunction

   task automatic settle();
      while (op_queue.size() != 0 || answer_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, csr_data_type data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_bounds(int lo, int hi);
      settle();
      write_csr(CSR_LOW_BOUND, {1'($urandom_range(0, 1)), index_type'(lo)});
      write_csr(CSR_HIGH_BOUND, csr_data_type'(hi));
      setting_count++;
   endtask

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   // Sender: bursts of beats with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_beat) begin
         req_beat = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (op_queue.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid <= 1'b1;
            req_bus.operation <= op_queue[0].operation;
            req_bus.entry_index <= op_queue[0].entry_index;
            req_bus.entry_value <= op_queue[0].entry_value;
            req_bus.search_key <= op_queue[0].search_key;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver: switch between stall patterns; hold off entirely under pressure.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ready_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(8, 64);
      end else begin
         stall_left--;
      end
      if (hold_off) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         case (stall_mode)
            READY_ALWAYS: rsp_bus.ready <= 1'b1;
            READY_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            default:      rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      hold_off = 1'b0;
      while (!(pressure_go && answer_queue.size() > 0 && op_queue.size() > 40))
         @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      search_answer_type want;
      if (reset) begin
         model_low = '0;
         model_high = -1;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LOW_BOUND:  model_low = csr_wr_data[INDEX_WIDTH-1:0];
               CSR_HIGH_BOUND: model_high = bound_type'(csr_wr_data);
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.operation == OP_LOAD) begin
               model_table[req_bus.entry_index] = req_bus.entry_value;
               load_count++;
            end else begin
               answer_queue.push_back(predict_lookup(req_bus.search_key));
               search_count++;
            end
            void'(op_queue.pop_front());
            req_beat = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answer_queue.size() == 0) begin
               flag_mismatch($sformatf("unexpected answer beat: found %0d pos %0d",
                                       rsp_bus.found, rsp_bus.position));
            end else begin
               want = answer_queue.pop_front();
               if (want.found) hit_count++;
               if (rsp_bus.found !== want.found || rsp_bus.position !== want.position)
                  flag_mismatch($sformatf(
                     "answer mismatch: expected found %0d pos %0d, got found %0d pos %0d",
                     want.found, want.position, rsp_bus.found, rsp_bus.position));
            end
         end
      end
   end

   initial begin
      int lo;
      int hi;
      int size;
      int searches;
      int random_start;
      bit first;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_LOW_BOUND;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_LOAD;
      req_bus.entry_index = '0;
      req_bus.entry_value = '0;
      req_bus.search_key = '0;
      rsp_bus.ready = 1'b0;
      req_beat = 1'b0;
      pressure_go = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_left = 0;
      stall_mode = READY_ALWAYS;
      foreach (stim_table[i]) stim_table[i] = '0;
      foreach (model_table[i]) model_table[i] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // empty range straight out of reset
      push_search('0);
      push_search(KEY_MAX);

      apply_bounds(0, 7);
      push_load(0, KEY_MIN);
      push_load(1, key_type'(-1000));
      push_load(2, key_type'(-1));
      push_load(3, key_type'(0));
      push_load(4, key_type'(1));
      push_load(5, key_type'(77));
      push_load(6, key_type'(1000));
      push_load(7, KEY_MAX);
      push_search(KEY_MIN);
      push_search(KEY_MAX);
      push_search(key_type'(0));
      push_search(key_type'(2));
      push_search(KEY_MIN + 1);

      apply_bounds(255, 255);
      push_load(255, key_type'(32'h5A5A_5A5A));
      push_search(key_type'(32'h5A5A_5A5A));
      push_search(key_type'(32'hA5A5_A5A5));

      // high below low
      apply_bounds(200, 100);
      push_search(key_type'(77));

      // break the ordering inside the range
      apply_bounds(0, 7);
      push_load(3, KEY_MAX);
      push_search(KEY_MAX);
      push_search(key_type'(1));

      pressure_go = 1'b1;
      first = 1'b1;
      random_start = queued_items;
      while (queued_items - random_start < RANDOM_ITEMS) begin
         size = $urandom_range(1, 12);
         searches = $urandom_range(6, 24);
         case (first ? 0 : $urandom_range(0, 39))
            0: begin
               lo = 0;
               hi = 255;
               searches = 120;
            end
            1: begin
               lo = $urandom_range(0, 255);
               hi = -1;
               searches = 4;
            end
            2: begin
               lo = $urandom_range(1, 255);
               hi = $urandom_range(0, lo - 1);
               searches = 4;
            end
            3: begin
               hi = 255;
               lo = 256 - size;
            end
            4: begin
               lo = 0;
               hi = size - 1;
            end
            default: begin
               lo = $urandom_range(0, 256 - size);
               hi = lo + size - 1;
            end
         endcase
         first = 1'b0;
         apply_bounds(lo, hi);
         plan_phase(lo, hi, searches);
      end

      settle();
      $display("covered %0d loads and %0d searches (%0d hits) over %0d bound settings",
               load_count, search_count, hit_count, setting_count);
      $display("%0d mismatches, %0d answers never delivered",
               mismatch_count, answer_queue.size());
      if (mismatch_count == 0 && answer_queue.size() == 0) begin
         $display("sorted_table_binary_search_top regression: pass");
      end else begin
         $display("sorted_table_binary_search_top regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_if.sv
hw/rtl/stbs_ram.sv
hw/rtl/sorted_table_binary_search_top.sv
sim/testbench.sv
